// File: rtl/core/pst_pkg.sv
package pst_pkg;

  // input and output field widths
  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned VertexW   = 4;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned VcountW   = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 3;

  // request opcodes
  localparam logic [OpcodeW-1:0] OP_WRITE_ENTRY = 2'd0;
  localparam logic [OpcodeW-1:0] OP_WRITE_EDGE  = 2'd1;
  localparam logic [OpcodeW-1:0] OP_RUN         = 2'd2;

  // register map (word index taken from paddr[2])
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic [VcountW-1:0] VERTEX_COUNT_RESET = 5'd16;

endpackage

// File: rtl/core/pst_ram.sv
module pst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/prim_spanning_tree.sv
// Minimum spanning tree engine over a stored adjacency matrix.
//
// Input channel (in_valid_i/in_ready_o) takes one request: write one matrix
// entry, write a symmetric edge, or run Prim's algorithm from start_vertex_i.
// Output channel (out_valid_o/out_ready_i) returns one tree edge per result;
// a run returns min(vertex_count, MAX_VERTICES)-1 edges, the last with last_o.
// An edge with found_o low means no crossing edge existed (0-0 edge).
// vertex_count is set through the APB port (byte address 0); the user must
// do so only while idle, as the block itself does not enforce it.
// Sequence: an entry write is done as it is taken; a symmetric write also
// writes the mirrored entry in ST_WR2. For each tree edge, a run with N
// vertices in use sweeps all N*N matrix entries through the single read port
// of the weight RAM and one shared compare unit, then rereads the chosen
// entry and emits it. in_ready_o is low during a run.
//
// Reset: the matrix RAM is cleared by a sweep of one entry per cycle
// (2**(2*clog2(MAX_VERTICES)) entries, 256 at the default size) during which
// no request is taken; APB writes are taken throughout.
// A stalled receiver holds the result in the output register; the run waits
// before emitting its next edge until that register is free.
module prim_spanning_tree #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [pst_pkg::OpcodeW-1:0]    opcode_i,
  input  logic [pst_pkg::VertexW-1:0]    row_i,
  input  logic [pst_pkg::VertexW-1:0]    col_i,
  input  logic [pst_pkg::WeightW-1:0]    weight_i,
  input  logic [pst_pkg::VertexW-1:0]    start_vertex_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pst_pkg::VertexW-1:0]    edge_from_o,
  output logic [pst_pkg::VertexW-1:0]    edge_to_o,
  output logic [pst_pkg::WeightW-1:0]    edge_weight_o,
  output logic                           found_o,
  output logic                           last_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pst_pkg::ApbAddrW-1:0]   paddr,
  input  logic [pst_pkg::ApbDataW-1:0]   pwdata,
  output logic [pst_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned IdxW  = $clog2(MAX_VERTICES);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned NvW   = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WR2   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FETCH = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam logic [MAX_VERTICES-1:0] OneHot = MAX_VERTICES'(1);

  logic [2:0]              state_q, state_d;
  logic [AddrW-1:0]        clr_q, clr_d;
  logic [pst_pkg::VcountW-1:0] vcount_q, vcount_d;

  logic [IdxW-1:0]         wr_row_q, wr_row_d, wr_col_q, wr_col_d;
  logic [WEIGHT_BITS-1:0]  wr_w_q, wr_w_d;
  logic                    wr_ok_q, wr_ok_d;

  logic [NvW-1:0]          nv_last_q, nv_last_d;
  logic [NvW-1:0]          k_q, k_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [IdxW-1:0]         i_q, i_d, j_q, j_d;
  logic                    p_valid_q, p_valid_d;
  logic [IdxW-1:0]         p_i_q, p_i_d, p_j_q, p_j_d;
  logic                    hit_q, hit_d;
  logic [WEIGHT_BITS-1:0]  best_q, best_d;
  logic [IdxW-1:0]         bx_q, bx_d, by_q, by_d;

  logic                    out_valid_q, out_valid_d;
  logic [IdxW-1:0]         o_from_q, o_from_d, o_to_q, o_to_d;
  logic [WEIGHT_BITS-1:0]  o_w_q, o_w_d;
  logic                    o_found_q, o_found_d, o_last_q, o_last_d;

  logic                    ram_we, ram_re;
  logic [AddrW-1:0]        ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0]  ram_wdata, ram_rdata;

  logic                    in_fire, in_ok, cfg_we, take, out_free;
  logic [7:0]              vc_ext;

  pst_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // apb register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == pst_pkg::REG_VERTEX_COUNT) ?
                  pst_pkg::ApbDataW'(vcount_q) : '0;

  always_comb begin
    vcount_d = vcount_q;
    if (cfg_we && (paddr[2] == pst_pkg::REG_VERTEX_COUNT)) begin
      vcount_d = pwdata[pst_pkg::VcountW-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_ok      = (8'(row_i) < 8'(MAX_VERTICES)) && (8'(col_i) < 8'(MAX_VERTICES));
  assign out_free   = !out_valid_q || out_ready_i;
  assign vc_ext     = 8'(vcount_q);

  // shared compare unit: one matrix entry per cycle against the running best
  assign take = p_valid_q && (ram_rdata != '0) && visited_q[p_i_q] &&
                !visited_q[p_j_q] && (!hit_q || (ram_rdata < best_q));

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wr_row_d    = wr_row_q;
    wr_col_d    = wr_col_q;
    wr_w_d      = wr_w_q;
    wr_ok_d     = wr_ok_q;
    nv_last_d   = nv_last_q;
    k_d         = k_q;
    visited_d   = visited_q;
    i_d         = i_q;
    j_d         = j_q;
    p_valid_d   = 1'b0;
    p_i_d       = i_q;
    p_j_d       = j_q;
    hit_d       = hit_q;
    best_d      = best_q;
    bx_d        = bx_q;
    by_d        = by_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_from_d    = o_from_q;
    o_to_d      = o_to_q;
    o_w_d       = o_w_q;
    o_found_d   = o_found_q;
    o_last_d    = o_last_q;
    ram_we      = 1'b0;
    ram_waddr   = {IdxW'(row_i), IdxW'(col_i)};
    ram_wdata   = WEIGHT_BITS'(weight_i);
    ram_re      = 1'b0;
    ram_raddr   = {i_q, j_q};

    // track the best crossing edge
    if (take) begin
      hit_d  = 1'b1;
      best_d = ram_rdata;
      bx_d   = p_i_q;
      by_d   = p_j_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (opcode_i)
            pst_pkg::OP_WRITE_ENTRY: begin
              ram_we = in_ok;
            end
            pst_pkg::OP_WRITE_EDGE: begin
              ram_we   = in_ok;
              wr_ok_d  = in_ok;
              wr_row_d = IdxW'(row_i);
              wr_col_d = IdxW'(col_i);
              wr_w_d   = WEIGHT_BITS'(weight_i);
              state_d  = ST_WR2;
            end
            pst_pkg::OP_RUN: begin
              visited_d = OneHot << start_vertex_i;
              k_d       = '0;
              i_d       = '0;
              j_d       = '0;
              hit_d     = 1'b0;
              bx_d      = '0;
              by_d      = '0;
              if (vc_ext > 8'(MAX_VERTICES)) begin
                nv_last_d = NvW'(MAX_VERTICES - 1);
              end else begin
                nv_last_d = NvW'(vc_ext - 8'd1);
              end
              if (vc_ext >= 8'd2) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WR2: begin
        ram_we    = wr_ok_q;
        ram_waddr = {wr_col_q, wr_row_q};
        ram_wdata = wr_w_q;
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        ram_re    = 1'b1;
        p_valid_d = 1'b1;
        if (NvW'(j_q) == nv_last_q) begin
          j_d = '0;
          if (NvW'(i_q) == nv_last_q) begin
            i_d     = '0;
            state_d = ST_DRAIN;
          end else begin
            i_d = i_q + IdxW'(1);
          end
        end else begin
          j_d = j_q + IdxW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_FETCH;
      end
      ST_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = {bx_q, by_q};
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_from_d    = bx_q;
          o_to_d      = by_q;
          o_w_d       = ram_rdata;
          o_found_d   = hit_q;
          o_last_d    = (k_q + NvW'(1) == nv_last_q);
          visited_d   = visited_q | (OneHot << by_q);
          k_d         = k_q + NvW'(1);
          hit_d       = 1'b0;
          bx_d        = '0;
          by_d        = '0;
          if (k_q + NvW'(1) == nv_last_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      vcount_q    <= pst_pkg::VERTEX_COUNT_RESET;
      visited_q   <= '0;
      k_q         <= '0;
      p_valid_q   <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      vcount_q    <= vcount_d;
      visited_q   <= visited_d;
      k_q         <= k_d;
      p_valid_q   <= p_valid_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    wr_row_q  <= wr_row_d;
    wr_col_q  <= wr_col_d;
    wr_w_q    <= wr_w_d;
    wr_ok_q   <= wr_ok_d;
    nv_last_q <= nv_last_d;
    i_q       <= i_d;
    j_q       <= j_d;
    p_i_q     <= p_i_d;
    p_j_q     <= p_j_d;
    best_q    <= best_d;
    bx_q      <= bx_d;
    by_q      <= by_d;
    o_from_q  <= o_from_d;
    o_to_q    <= o_to_d;
    o_w_q     <= o_w_d;
    o_found_q <= o_found_d;
    o_last_q  <= o_last_d;
  end

  // result outputs
  assign out_valid_o   = out_valid_q;
  assign edge_from_o   = pst_pkg::VertexW'(o_from_q);
  assign edge_to_o     = pst_pkg::VertexW'(o_to_q);
  assign edge_weight_o = pst_pkg::WeightW'(o_w_q);
  assign found_o       = o_found_q;
  assign last_o        = o_last_q;

endmodule

// File: rtl/core/pst_checker.sv
module pst_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [pst_pkg::OpcodeW-1:0]  opcode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pst_pkg::VertexW-1:0]  edge_from_o,
  input logic [pst_pkg::VertexW-1:0]  edge_to_o,
  input logic [pst_pkg::WeightW-1:0]  edge_weight_o,
  input logic                         found_o,
  input logic                         last_o
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(edge_from_o) &&
    $stable(edge_to_o) && $stable(edge_weight_o) && $stable(found_o) && $stable(last_o))
    else $error("result changed while stalled");

  // a missing crossing edge is reported as the 0-0 edge
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (edge_from_o == '0) && (edge_to_o == '0))
    else $error("not-found result with nonzero vertices");

  // a write request never produces a result in the next cycle
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i != pst_pkg::OP_RUN) |=> !$rose(out_valid_o))
    else $error("result raised by a write request");

  // the request side is closed when a new result other than the last appears
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !last_o |-> !in_ready_o)
    else $error("request taken in the middle of a run");

endmodule

bind prim_spanning_tree pst_checker u_pst_checker (.*);
